// File: design/pimp_pkg.sv
// package for the image message parser: phase codes, field selects, error codes
// no dependencies
package pimp_pkg;
    localparam int LengthBitsDefault = 32;
    localparam int CfgW = 27;
    localparam logic [CfgW-1:0] MaxFrameReset = 27'h4000000;

    typedef enum logic [2:0] {
        PH_TAG = 3'd0, PH_VALUE = 3'd1, PH_LEN = 3'd2,
        PH_SKIP = 3'd3, PH_PIXEL = 3'd4, PH_ERR = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        SEL_NONE = 3'd0, SEL_N_FORMAT = 3'd1, SEL_N_WIDTH = 3'd2, SEL_N_HEIGHT = 3'd3,
        SEL_T_WIDTH = 3'd4, SEL_T_HEIGHT = 3'd5, SEL_NESTED = 3'd6, SEL_PIXELS = 3'd7
    } sel_t;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_VARINT = 3'd1;
    localparam logic [2:0] ERR_WIRE = 3'd2;
    localparam logic [2:0] ERR_MISSING = 3'd3;
    localparam logic [2:0] ERR_FORMAT = 3'd4;
    localparam logic [2:0] ERR_SIZE = 3'd5;

    typedef struct packed {
        logic       start;
        logic [1:0] bpp;
    } mul_req_t;
endpackage

// File: design/pimp_if.sv
// valid/ready channel interfaces for bytes, results and configuration
// depends on nothing
interface pimp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       is_last;
    modport source (output valid, payload_byte, is_last, input ready);
    modport sink (input valid, payload_byte, is_last, output ready);
endinterface

interface pimp_out_if;
    logic        valid;
    logic        ready;
    logic        pixel_valid;
    logic [7:0]  pixel_data;
    logic        segment_first;
    logic        done_res;
    logic        decode_ok;
    logic [2:0]  error_code;
    logic [26:0] frame_width;
    logic [26:0] frame_height;
    logic [1:0]  pixel_format;
    modport source (output valid, pixel_valid, pixel_data, segment_first, done_res,
        decode_ok, error_code, frame_width, frame_height, pixel_format, input ready);
    modport sink (input valid, pixel_valid, pixel_data, segment_first, done_res,
        decode_ok, error_code, frame_width, frame_height, pixel_format, output ready);
endinterface

interface pimp_cfg_if;
    logic        valid;
    logic        ready;
    logic [26:0] max_frame_bytes;
    modport source (output valid, max_frame_bytes, input ready);
    modport sink (input valid, max_frame_bytes, output ready);
endinterface

// File: design/pimp_mul.sv
// shift-add multiplier: width*height then times bytes per pixel
// depends on pimp_pkg
module pimp_mul
    import pimp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mul_req_t    req,
    input  logic [30:0] op_a,
    input  logic [30:0] op_b,
    output logic        busy,
    output logic [63:0] product
);
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [30:0] mplier_reg, mplier_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  bpp_reg, bpp_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        bpp_next    = bpp_reg;
        if (req.start)
        begin
            acc_next    = '0;
            mcand_next  = {33'd0, op_a};
            mplier_next = op_b;
            cnt_next    = 6'd33;
            bpp_next    = req.bpp;
        end
        else if (cnt_reg > 6'd2)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = {mcand_reg[62:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[30:1]};
            cnt_next    = cnt_reg - 6'd1;
        end
        else if (cnt_reg == 6'd2)
        begin
            // times 3 or 4
            acc_next = (bpp_reg == 2'd3) ? acc_reg + {acc_reg[62:0], 1'b0}
                                         : {acc_reg[61:0], 2'b00};
            cnt_next = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        bpp_reg    <= bpp_next;
    end

    assign busy    = cnt_reg != 6'd0;
    assign product = acc_reg;
endmodule

// File: design/protobuf_image_message_parser_core.sv
// image message parser: one byte per item for parse
// a non-last pixel byte is shown on the output in the cycle after acceptance
// last item: the verdict goes through ST_MUL, ST_WAIT (the 31x31 shift-add multiplier runs) and ST_OUT;
// ST_WAIT is skipped when a check has already failed
// throughput: one item per cycle while the output is not stalled, except the final item of a message
// reset: async active low clears all parse state; max_frame_bytes resets to 2^26
module protobuf_image_message_parser_core
    import pimp_pkg::*;
#(
    parameter int LENGTH_BITS = LengthBitsDefault
)
(
    input  logic clk,
    input  logic rst_n,
    pimp_in_if.sink   in_ch,
    pimp_out_if.source out_ch,
    pimp_cfg_if.sink  cfg_ch
);
    typedef enum logic [3:0] {
        ST_RUN = 4'b0001, ST_MUL = 4'b0010, ST_WAIT = 4'b0100, ST_OUT = 4'b1000
    } st_t;

    st_t         st_reg, st_next;
    logic [26:0] maxf_reg;
    phase_t      ph_reg, ph_next;
    logic        nest_reg, nest_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  sh_reg, sh_next;
    sel_t        sel_reg, sel_next;
    logic [63:0] skip_reg, skip_next, nrem_reg, nrem_next, plen_reg, plen_next;
    logic [31:0] w_reg, w_next, h_reg, h_next, f_reg, f_next;
    logic [2:0]  err_reg, err_next;
    logic        ov_reg, ov_next;
    logic        opix_reg, opix_next, ofirst_reg, ofirst_next, odone_reg, odone_next;
    logic        ook_reg, ook_next;
    logic [2:0]  oerr_reg, oerr_next;
    logic [7:0]  odata_reg, odata_next;
    logic [26:0] ow_reg, ow_next, oh_reg, oh_next;
    logic [1:0]  of_reg, of_next;

    mul_req_t    mreq;
    logic        mbusy;
    logic [63:0] mprod;

    pimp_mul u_mul (
        .clk(clk), .rst_n(rst_n), .req(mreq), .op_a(w_reg[30:0]), .op_b(h_reg[30:0]),
        .busy(mbusy), .product(mprod)
    );

    logic        acc_in;
    logic [7:0]  b;
    logic [63:0] v, tag_field;
    logic [63:0] len_mask;
    logic [2:0]  wire_t;
    logic        vdone, pix, first, out_free;
    logic [2:0]  pre_err;

    assign len_mask = (LENGTH_BITS >= 64) ? '1 : ((64'd1 << LENGTH_BITS) - 64'd1);
    assign out_free = !ov_reg || out_ch.ready;
    assign in_ch.ready = (st_reg == ST_RUN) && out_free;
    assign acc_in = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign b = in_ch.payload_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            maxf_reg <= MaxFrameReset;
        else if (cfg_ch.valid)
            maxf_reg <= cfg_ch.max_frame_bytes;
    end

    always_comb
    begin
        st_next = st_reg; ph_next = ph_reg; nest_next = nest_reg; acc_next = acc_reg;
        sh_next = sh_reg; sel_next = sel_reg; skip_next = skip_reg; nrem_next = nrem_reg;
        plen_next = plen_reg; w_next = w_reg; h_next = h_reg; f_next = f_reg;
        err_next = err_reg; ov_next = ov_reg;
        opix_next = opix_reg; ofirst_next = ofirst_reg; odone_next = odone_reg;
        ook_next = ook_reg; oerr_next = oerr_reg; odata_next = odata_reg;
        ow_next = ow_reg; oh_next = oh_reg; of_next = of_reg;
        mreq = '0;
        mreq.bpp = (f_reg == 32'd2) ? 2'd3 : 2'd0;
        pix = 1'b0; first = 1'b0; vdone = 1'b0;
        v = acc_reg | ({57'd0, b[6:0]} << ((7 * sh_reg) & 63));
        tag_field = v >> 3;
        wire_t = v[2:0];
        pre_err = ERR_NONE;
        if (out_ch.ready)
            ov_next = 1'b0;

        case (st_reg)
        ST_RUN:
        begin
            if (acc_in)
            begin
                if (ph_reg != PH_ERR)
                begin
                    if (nest_reg && nrem_reg != '0)
                        nrem_next = nrem_reg - 64'd1;
                    case (ph_reg)
                    PH_TAG, PH_VALUE, PH_LEN:
                    begin
                        acc_next = v;
                        if (!b[7])
                        begin
                            acc_next = '0;
                            sh_next = '0;
                            vdone = 1'b1;
                        end
                        else if (sh_reg == 4'd9)
                        begin
                            ph_next = PH_ERR; err_next = ERR_VARINT;
                        end
                        else
                            sh_next = sh_reg + 4'd1;
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_reg - 64'd1;
                        if (skip_reg == 64'd1) ph_next = PH_TAG;
                    end
                    PH_PIXEL:
                    begin
                        pix = 1'b1;
                        first = skip_reg == plen_reg;
                        skip_next = skip_reg - 64'd1;
                        if (skip_reg == 64'd1) ph_next = PH_TAG;
                    end
                    default:
                    begin
                        ph_next = PH_ERR; err_next = ERR_VARINT;
                    end
                    endcase
                    if (vdone)
                    begin
                        case (ph_reg)
                        PH_TAG:
                        begin
                            logic do_skip;
                            logic [63:0] sn;
                            do_skip = 1'b0; sn = '0;
                            if (nest_reg && wire_t == 3'd0 && (tag_field == 64'd1 ||
                                tag_field == 64'd3 || tag_field == 64'd4))
                            begin
                                sel_next = (tag_field == 64'd1) ? SEL_N_FORMAT :
                                           (tag_field == 64'd3) ? SEL_N_WIDTH : SEL_N_HEIGHT;
                                ph_next = PH_VALUE;
                            end
                            else if (!nest_reg && tag_field == 64'd1 && wire_t == 3'd2)
                            begin
                                sel_next = SEL_NESTED; ph_next = PH_LEN;
                            end
                            else if (!nest_reg && (tag_field == 64'd2 ||
                                     tag_field == 64'd3) && wire_t == 3'd0)
                            begin
                                sel_next = (tag_field == 64'd2) ? SEL_T_WIDTH : SEL_T_HEIGHT;
                                ph_next = PH_VALUE;
                            end
                            else if (!nest_reg && tag_field == 64'd4 && wire_t == 3'd2)
                            begin
                                sel_next = SEL_PIXELS; ph_next = PH_LEN;
                            end
                            else if (wire_t == 3'd0)
                            begin
                                sel_next = SEL_NONE; ph_next = PH_VALUE;
                            end
                            else if (wire_t == 3'd2)
                            begin
                                sel_next = SEL_NONE; ph_next = PH_LEN;
                            end
                            else if (wire_t == 3'd1 || wire_t == 3'd5)
                            begin
                                do_skip = 1'b1;
                                sn = (wire_t == 3'd1) ? 64'd8 : 64'd4;
                            end
                            else
                            begin
                                ph_next = PH_ERR; err_next = ERR_WIRE;
                            end
                            if (do_skip)
                            begin
                                if (nest_reg && sn > nrem_next)
                                begin
                                    ph_next = PH_ERR; err_next = ERR_VARINT;
                                end
                                else
                                begin
                                    skip_next = sn; ph_next = PH_SKIP;
                                end
                            end
                        end
                        PH_VALUE:
                        begin
                            ph_next = PH_TAG;
                            case (sel_reg)
                            SEL_N_FORMAT: f_next = v[31:0];
                            SEL_N_WIDTH:  w_next = v[31:0];
                            SEL_N_HEIGHT: h_next = v[31:0];
                            SEL_T_WIDTH:  if (w_reg == '0) w_next = v[31:0];
                            SEL_T_HEIGHT: if (h_reg == '0) h_next = v[31:0];
                            default: ;
                            endcase
                        end
                        default:
                        begin
                            if ((v & ~len_mask) != '0)
                            begin
                                ph_next = PH_ERR; err_next = ERR_VARINT;
                            end
                            else if (sel_reg == SEL_NESTED)
                            begin
                                ph_next = PH_TAG;
                                if (v != '0)
                                begin
                                    nest_next = 1'b1; nrem_next = v;
                                end
                            end
                            else if (sel_reg == SEL_PIXELS)
                            begin
                                plen_next = v;
                                skip_next = v;
                                ph_next = (v == '0) ? PH_TAG : PH_PIXEL;
                            end
                            else if (nest_reg && v > nrem_next)
                            begin
                                ph_next = PH_ERR; err_next = ERR_VARINT;
                            end
                            else
                            begin
                                skip_next = v;
                                ph_next = (v == '0) ? PH_TAG : PH_SKIP;
                            end
                        end
                        endcase
                    end
                    if (nest_reg && ph_next != PH_ERR && nrem_next == '0)
                    begin
                        if (ph_next == PH_TAG && sh_next == '0)
                            nest_next = 1'b0;
                        else
                        begin
                            ph_next = PH_ERR; err_next = ERR_VARINT;
                        end
                    end
                end
                opix_next = pix; ofirst_next = first;
                odata_next = pix ? b : 8'd0;
                odone_next = 1'b0; ook_next = 1'b0; oerr_next = ERR_NONE;
                ow_next = '0; oh_next = '0; of_next = '0;
                if (in_ch.is_last)
                begin
                    if (ph_next == PH_ERR) pre_err = err_next;
                    else if (ph_next != PH_TAG || sh_next != '0 || nest_next)
                        pre_err = ERR_VARINT;
                    else if (w_next == '0 || w_next[31] || h_next == '0 || h_next[31] ||
                             plen_next == '0)
                        pre_err = ERR_MISSING;
                    else if (f_next != 32'd1 && f_next != 32'd2)
                        pre_err = ERR_FORMAT;
                    else
                        pre_err = ERR_NONE;
                    ph_next = ph_next == PH_ERR ? PH_ERR : PH_TAG;
                    err_next = pre_err;
                    odone_next = 1'b1;
                    st_next = ST_MUL;
                end
                else if (pix)
                    ov_next = 1'b1;
            end
        end
        ST_MUL:
        begin
            // all holds are settled; start the product when the check is still open
            if (err_reg == ERR_NONE)
            begin
                mreq.start = 1'b1;
                st_next = ST_WAIT;
            end
            else
                st_next = ST_OUT;
        end
        ST_WAIT:
        begin
            if (!mbusy)
            begin
                if (mprod > {37'd0, maxf_reg} || mprod != plen_reg)
                    err_next = ERR_SIZE;
                st_next = ST_OUT;
            end
        end
        ST_OUT:
        begin
            if (out_free)
            begin
                ov_next = 1'b1;
                oerr_next = err_reg;
                ook_next = err_reg == ERR_NONE;
                ow_next = (err_reg == ERR_NONE) ? w_reg[26:0] : '0;
                oh_next = (err_reg == ERR_NONE) ? h_reg[26:0] : '0;
                of_next = (err_reg == ERR_NONE) ? f_reg[1:0] : '0;
                ph_next = PH_TAG; nest_next = 1'b0; acc_next = '0; sh_next = '0;
                sel_next = SEL_NONE; skip_next = '0; nrem_next = '0; plen_next = '0;
                w_next = '0; h_next = '0; f_next = 32'd1; err_next = ERR_NONE;
                st_next = ST_RUN;
            end
        end
        default: st_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RUN; ph_reg <= PH_TAG; nest_reg <= 1'b0; acc_reg <= '0;
            sh_reg <= '0; sel_reg <= SEL_NONE; skip_reg <= '0; nrem_reg <= '0;
            plen_reg <= '0; w_reg <= '0; h_reg <= '0; f_reg <= 32'd1;
            err_reg <= ERR_NONE; ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; ph_reg <= ph_next; nest_reg <= nest_next;
            acc_reg <= acc_next; sh_reg <= sh_next; sel_reg <= sel_next;
            skip_reg <= skip_next; nrem_reg <= nrem_next; plen_reg <= plen_next;
            w_reg <= w_next; h_reg <= h_next; f_reg <= f_next;
            err_reg <= err_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opix_reg <= opix_next; ofirst_reg <= ofirst_next; odone_reg <= odone_next;
        ook_reg <= ook_next; oerr_reg <= oerr_next; odata_reg <= odata_next;
        ow_reg <= ow_next; oh_reg <= oh_next; of_reg <= of_next;
    end

    assign out_ch.valid         = ov_reg;
    assign out_ch.pixel_valid   = opix_reg;
    assign out_ch.pixel_data    = odata_reg;
    assign out_ch.segment_first = ofirst_reg;
    assign out_ch.done_res      = odone_reg;
    assign out_ch.decode_ok     = ook_reg;
    assign out_ch.error_code    = oerr_reg;
    assign out_ch.frame_width   = ow_reg;
    assign out_ch.frame_height  = oh_reg;
    assign out_ch.pixel_format  = of_reg;
endmodule

// File: design/pimp_checker.sv
// port-level checks for the image message parser
// depends on pimp_pkg and the top level ports
module pimp_checker
    import pimp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_done,
    input logic        out_ok,
    input logic [2:0]  out_err,
    input logic [26:0] out_w
);
    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_done |-> (out_ok == (out_err == ERR_NONE)))
        else $error("ok flag disagrees with error code");
    a_no_dims: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ok |-> out_w == '0)
        else $error("width shown without ok");
    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("accepted item after last byte before verdict");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
endmodule

bind protobuf_image_message_parser_core pimp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_last(in_ch.is_last), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_done(out_ch.done_res), .out_ok(out_ch.decode_ok), .out_err(out_ch.error_code),
    .out_w(out_ch.frame_width)
);
